// ===== hw/rtl/fader_ramp_engine_macros.svh =====
// Assertion macros used by the fader ramp engine top level.
`ifndef FADER_RAMP_ENGINE_MACROS_SVH
`define FADER_RAMP_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FRE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fader ramp engine check failed");

// Next-cycle implication, disabled during reset.
`define FRE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fader ramp engine check failed");

`endif

// ===== hw/rtl/fre_pkg.sv =====
// Types, constants and lookup functions of the fader ramp engine.
package fre_pkg;

  localparam int NumFaders = 8;
  localparam int DivNumW   = 20;
  localparam int DivDenW   = 13;
  localparam logic [12:0] TimeDiv = 13'd126;

  localparam logic [1:0] CfgTypeMask    = 2'd0;
  localparam logic [1:0] CfgPresentMask = 2'd1;
  localparam logic [1:0] CfgVelSens     = 2'd2;

  typedef struct packed {
    logic [7:0] type_mask;
    logic [7:0] present_mask;
    logic       vel_sens;
  } fre_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] fader;
    logic [6:0] value;
    logic       last;
  } fre_push_t;

  function automatic logic [6:0] stop_val(input logic typ, input logic [2:0] c,
                                          input logic [1:0] j);
    logic [6:0] r;
    r = 7'd0;
    if (!typ) begin
      case ({c, j})
        5'd0:  r = 7'd0;   5'd1:  r = 7'd4;   5'd2:  r = 7'd8;   5'd3:  r = 7'd12;
        5'd4:  r = 7'd17;  5'd5:  r = 7'd21;  5'd6:  r = 7'd25;  5'd7:  r = 7'd29;
        5'd8:  r = 7'd34;  5'd9:  r = 7'd38;  5'd10: r = 7'd42;  5'd11: r = 7'd47;
        5'd12: r = 7'd52;  5'd13: r = 7'd56;  5'd14: r = 7'd60;  5'd15: r = 7'd65;
        5'd16: r = 7'd70;  5'd17: r = 7'd74;  5'd18: r = 7'd79;  5'd19: r = 7'd84;
        5'd20: r = 7'd89;  5'd21: r = 7'd93;  5'd22: r = 7'd98;  5'd23: r = 7'd103;
        5'd24: r = 7'd108; 5'd25: r = 7'd112; 5'd26: r = 7'd117; 5'd27: r = 7'd122;
        5'd28: r = 7'd127;
        default: r = 7'd0;
      endcase
    end else begin
      case ({c, j})
        5'd4:  r = 7'd21;  5'd5:  r = 7'd16;  5'd6:  r = 7'd11;  5'd7:  r = 7'd6;
        5'd8:  r = 7'd42;  5'd9:  r = 7'd37;  5'd10: r = 7'd32;  5'd11: r = 7'd27;
        5'd12: r = 7'd63;  5'd13: r = 7'd58;  5'd14: r = 7'd53;  5'd15: r = 7'd48;
        5'd16: r = 7'd64;  5'd17: r = 7'd69;  5'd18: r = 7'd74;  5'd19: r = 7'd79;
        5'd20: r = 7'd85;  5'd21: r = 7'd90;  5'd22: r = 7'd95;  5'd23: r = 7'd100;
        5'd24: r = 7'd106; 5'd25: r = 7'd111; 5'd26: r = 7'd116; 5'd27: r = 7'd121;
        5'd28: r = 7'd127;
        default: r = 7'd0;
      endcase
    end
    return r;
  endfunction

  // Retrigger on a stop already reached moves to its next fine substep.
  function automatic logic [6:0] stop_target(input logic typ, input logic [2:0] c,
                                             input logic [6:0] cur);
    logic [6:0] fin;
    logic       found;
    fin   = stop_val(typ, c, 2'd0);
    found = 1'b0;
    if ((!typ && c != 3'd7) || (typ && c != 3'd0 && c != 3'd7)) begin
      for (int j = 0; j < 3; j++) begin
        if (!found && stop_val(typ, c, 2'(j)) == cur) begin
          fin   = stop_val(typ, c, 2'(j + 1));
          found = 1'b1;
        end
      end
    end
    return fin;
  endfunction

  function automatic logic [12:0] ramp_time(input logic [6:0] v);
    logic [12:0] r;
    logic [12:0] m;
    r = 13'd126;
    m = 13'd0;
    if (v < 7'd48) begin
      case (v[5:2])
        4'd0: r = 13'd8062; 4'd1: r = 13'd6450; 4'd2: r = 13'd5374; 4'd3: r = 13'd4607;
        4'd4: r = 13'd4031; 4'd5: r = 13'd3583; 4'd6: r = 13'd3224; 4'd7: r = 13'd2932;
        4'd8: r = 13'd2688; 4'd9: r = 13'd2481; 4'd10: r = 13'd2303;
        4'd11: r = 13'd2150;
        default: r = 13'd126;
      endcase
    end else if (v < 7'd112) begin
      case (v[3:0])
        4'd0: m = 13'd2016;  4'd1: m = 13'd1896;  4'd2: m = 13'd1792;  4'd3: m = 13'd1696;
        4'd4: m = 13'd1613;  4'd5: m = 13'd1536;  4'd6: m = 13'd1467;  4'd7: m = 13'd1403;
        4'd8: m = 13'd1344;  4'd9: m = 13'd1291;  4'd10: m = 13'd1240; 4'd11: m = 13'd1192;
        4'd12: m = 13'd1152; 4'd13: m = 13'd1112; 4'd14: m = 13'd1076; 4'd15: m = 13'd1040;
        default: m = 13'd0;
      endcase
      r = m >> (2'(v[6:4] - 3'd3));
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/fader_ramp_engine.sv =====
// Top level of the fader ramp engine: configuration, sequencer and output register.
//
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i / in_stall_o | mode, fader_index, stop_index, velocity
//  out     | source    | out_valid_o / out_stall_i | send_valid, out_fader, cc_value, last
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A press that starts a ramp stalls the input through lookup, two divider passes and a
// restart state between them. A press sent at once stalls it until the output takes its value.
// A tick walks one fader a cycle, except while it waits on a stalled output, then flushes.
// An ignored press does not stall the input.
// Reset sets every fader to 127 with no ramp running and clears the masks.
// out_stall_i holds the output register; the walk waits only when a second result is due.
`include "fader_ramp_engine_macros.svh"

module fader_ramp_engine #(
  parameter int NUM_FADERS = fre_pkg::NumFaders
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       in_mode_i,
  input  logic [2:0] in_fader_index_i,
  input  logic [2:0] in_stop_index_i,
  input  logic [6:0] in_velocity_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       send_valid_o,
  output logic [2:0] out_fader_o,
  output logic [6:0] cc_value_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  fre_pkg::fre_cfg_t  cfg_q;
  fre_pkg::fre_push_t push;
  logic busy, out_free, in_acc;
  logic out_v_q;
  logic [2:0] out_f_q;
  logic [6:0] out_val_q;
  logic out_last_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign in_acc      = in_valid_i && !busy;
  assign out_free    = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fre_pkg::CfgTypeMask:    cfg_q.type_mask    <= cfg_data_i;
        fre_pkg::CfgPresentMask: cfg_q.present_mask <= cfg_data_i;
        fre_pkg::CfgVelSens:     cfg_q.vel_sens     <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  fre_ctrl #(.NUM_FADERS(NUM_FADERS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start_i    (in_acc),
    .mode_i     (in_mode_i),
    .fader_i    (in_fader_index_i),
    .stop_i     (in_stop_index_i),
    .vel_i      (in_velocity_i),
    .busy_o     (busy),
    .out_free_i (out_free),
    .push_o     (push)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= push.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && push.valid) begin
      out_f_q    <= push.fader;
      out_val_q  <= push.value;
      out_last_q <= push.last;
    end
  end

  assign out_valid_o  = out_v_q;
  assign send_valid_o = 1'b1;
  assign out_fader_o  = out_f_q;
  assign cc_value_o   = out_val_q;
  assign last_o       = out_last_q;

  `FRE_ASSERT_NEXT(a_zero_vel_ignored, in_acc && !in_mode_i && in_velocity_i == 7'd0, !in_stall_o)
  `FRE_ASSERT_NEXT(a_tick_walks, in_acc && in_mode_i, in_stall_o)
  `FRE_ASSERT_NOW(a_push_when_free, push.valid, out_free)
endmodule

// ===== hw/rtl/fre_serial_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module fre_serial_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fre_pkg::DivNumW-1:0]   num_i,
  input  logic [fre_pkg::DivDenW-1:0]   den_i,
  output logic                          done_o,
  output logic [fre_pkg::DivNumW-1:0]   quo_o
);
  localparam int NW = fre_pkg::DivNumW;
  localparam int DW = fre_pkg::DivDenW;
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_q, rem_d, den_q;
  logic [NW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[NW-1]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit and subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = DW'(trial - {1'b0, den_q});
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ===== hw/rtl/fre_ctrl.sv =====
// Press and tick sequencer with per-fader ramp state.
module fre_ctrl #(
  parameter int NUM_FADERS = fre_pkg::NumFaders
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fre_pkg::fre_cfg_t  cfg_i,
  input  logic               start_i,
  input  logic               mode_i,
  input  logic [2:0]         fader_i,
  input  logic [2:0]         stop_i,
  input  logic [6:0]         vel_i,
  output logic               busy_o,
  input  logic               out_free_i,
  output fre_pkg::fre_push_t push_o
);
  localparam int IW = (NUM_FADERS > 1) ? $clog2(NUM_FADERS) : 1;
  localparam int NW = fre_pkg::DivNumW;
  localparam int DW = fre_pkg::DivDenW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_DIV2A = 3'd3;
  localparam logic [2:0] S_DIV2  = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;
  localparam logic [2:0] S_SEND  = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] f_q;
  logic [2:0]    c_q;
  logic [6:0]    v_q, diff_q;
  logic          dir_q, slow_q;
  logic [12:0]   time_q;
  logic          pend_v_q;
  logic [2:0]    pend_f_q;
  logic [6:0]    pend_val_q;

  logic [6:0] cur_q [NUM_FADERS];
  logic [6:0] tgt_q [NUM_FADERS];
  logic [7:0] per_q [NUM_FADERS];
  logic [7:0] tel_q [NUM_FADERS];
  logic [7:0] stl_q [NUM_FADERS];
  logic [2:0] ssz_q [NUM_FADERS];

  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;

  logic [3:0]  idx4;
  logic        present;
  logic        press_ok;
  logic [6:0]  cur, fin, diff;
  logic        dir;
  logic [NW-1:0] prod;
  logic        running, hit, stall_w;
  logic [7:0]  tel_inc, stl_n;
  logic [6:0]  nv;
  logic [2:0]  q3;

  assign idx4     = 4'(f_q);
  assign present  = (idx4 < 4'd8) && cfg_i.present_mask[idx4[2:0]];
  assign press_ok = (vel_i != 7'd0) && (5'({2'b00, fader_i}) < 5'(NUM_FADERS))
                    && cfg_i.present_mask[fader_i];

  assign cur  = cur_q[f_q];
  assign fin  = fre_pkg::stop_target(cfg_i.type_mask[idx4[2:0]], c_q, cur);
  assign dir  = cur < fin;
  assign diff = dir ? 7'(fin - cur) : 7'(cur - fin);
  assign prod = NW'(fre_pkg::ramp_time(v_q)) * NW'(7'(diff - 7'd1));

  assign running = present && (stl_q[f_q] != 8'd0);
  assign tel_inc = tel_q[f_q] + 8'd1;
  assign hit     = running && (tel_inc >= per_q[f_q]);
  assign stl_n   = stl_q[f_q] - 8'd1;
  assign nv      = (stl_n == 8'd0) ? tgt_q[f_q]
                   : 7'(cur + {{4{ssz_q[f_q][2]}}, ssz_q[f_q]});
  assign stall_w = hit && pend_v_q && !out_free_i;
  assign q3      = div_quo[2:0];

  always_comb begin
    div_start = 1'b0;
    div_num   = prod;
    div_den   = fre_pkg::TimeDiv;
    if (state_q == S_LOOK) begin
      div_start = diff > 7'd1;
    end else if (state_q == S_DIV2A) begin
      div_start = 1'b1;
      if (slow_q) begin
        div_num = NW'(time_q);
        div_den = DW'(diff_q);
      end else begin
        div_num = NW'(diff_q);
        div_den = time_q;
      end
    end
  end

  fre_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d = state_q;
    push_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = mode_i ? S_WALK : (press_ok ? S_LOOK : S_IDLE);
        end
      end
      S_LOOK:  state_d = (diff > 7'd1) ? S_DIV1 : S_SEND;
      S_DIV1:  state_d = div_done ? S_DIV2A : S_DIV1;
      S_DIV2A: state_d = S_DIV2;
      S_DIV2:  state_d = div_done ? S_IDLE : S_DIV2;
      S_WALK: begin
        if (hit && pend_v_q && out_free_i) begin
          push_o = '{valid: 1'b1, fader: pend_f_q, value: pend_val_q, last: 1'b0};
        end
        if (!stall_w && f_q == IW'(NUM_FADERS - 1)) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free_i) begin
          push_o  = '{valid: 1'b1, fader: pend_f_q, value: pend_val_q, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_SEND: begin
        if (out_free_i) begin
          push_o  = '{valid: 1'b1, fader: pend_f_q, value: pend_val_q, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pend_v_q <= 1'b0;
      f_q      <= '0;
      for (int i = 0; i < NUM_FADERS; i++) begin
        cur_q[i] <= 7'd127;
        tgt_q[i] <= 7'd127;
        per_q[i] <= 8'd0;
        tel_q[i] <= 8'd0;
        stl_q[i] <= 8'd0;
        ssz_q[i] <= 3'd0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            f_q <= mode_i ? '0 : IW'(fader_i);
          end
        end
        S_LOOK: begin
          tgt_q[f_q] <= fin;
          tel_q[f_q] <= 8'd0;
          stl_q[f_q] <= 8'd0;
          if (diff == 7'd1) begin
            cur_q[f_q] <= fin;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            if (slow_q) begin
              per_q[f_q] <= div_quo[7:0];
              stl_q[f_q] <= 8'(diff_q);
              ssz_q[f_q] <= dir_q ? 3'b001 : 3'b111;
            end else begin
              per_q[f_q] <= 8'd1;
              stl_q[f_q] <= time_q[7:0];
              ssz_q[f_q] <= dir_q ? q3 : 3'(3'd0 - q3);
            end
          end
        end
        S_WALK: begin
          if (running && !stall_w) begin
            if (hit) begin
              cur_q[f_q] <= nv;
              stl_q[f_q] <= stl_n;
              tel_q[f_q] <= 8'd0;
            end else begin
              tel_q[f_q] <= tel_inc;
            end
          end
          if (hit && !stall_w) begin
            pend_v_q <= 1'b1;
          end
          if (!stall_w && f_q != IW'(NUM_FADERS - 1)) begin
            f_q <= f_q + IW'(1);
          end
        end
        S_FLUSH: begin
          if (out_free_i) begin
            pend_v_q <= 1'b0;
          end
        end
        S_SEND: begin
          if (out_free_i) begin
            pend_v_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (state_q == S_LOOK && diff <= 7'd1) begin
        pend_v_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      c_q <= stop_i;
      v_q <= cfg_i.vel_sens ? vel_i : 7'd127;
    end
    if (state_q == S_LOOK) begin
      diff_q     <= diff;
      dir_q      <= dir;
      pend_f_q   <= idx4[2:0];
      pend_val_q <= fin;
    end
    if (state_q == S_DIV1 && div_done) begin
      time_q <= div_quo[12:0];
      slow_q <= div_quo[12:0] >= 13'(diff_q);
    end
    if (state_q == S_WALK && hit && !stall_w) begin
      pend_f_q   <= idx4[2:0];
      pend_val_q <= nv;
    end
  end

  assign busy_o = state_q != S_IDLE;
endmodule
